>>> src/pbr_pkg.sv
package pbr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_W    = 24;
    localparam int STAMP_W   = 32;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = 32;

    localparam logic [2:0] OP_PIN   = 3'd0;
    localparam logic [2:0] OP_UNPIN = 3'd1;
    localparam logic [2:0] OP_DIRTY = 3'd2;
    localparam logic [2:0] OP_FORCE = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOTF = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;
    localparam logic [1:0] POL_LFU   = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;

    typedef struct packed {
        logic [2:0]        op;
        logic [PAGE_W-1:0] page_num;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        frame;
        logic              hit;
        logic              read_valid;
        logic              writeback_valid;
        logic [PAGE_W-1:0] writeback_page;
        logic              last;
        logic [CNT_W-1:0]  reads_total;
        logic [CNT_W-1:0]  writes_total;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_VINIT, S_VSCAN, S_SEEK,
        S_FILL, S_HIT, S_UPD, S_RESP, S_FLUSH, S_FEND
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_LOOK, CMD_DECIDE, CMD_VINIT, CMD_VSCAN,
        CMD_SEEK, CMD_FILL, CMD_HIT, CMD_UPD, CMD_RESP, CMD_FLUSH, CMD_FEND
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] stat;
    } t_ctl;

    typedef struct packed {
        logic found;
        logic has_empty;
        logic any_unp;
        logic look_done;
        logic vict_done;
        logic scan_end;
    } t_sts;

endpackage

>>> src/page_buffer_replacement_unit.sv
// Page buffer replacement unit: frame table with FIFO, LRU, CLOCK and LFU eviction.
// Command channel: raise i_start with i_in (op, page_num); the word is taken at an
// edge where i_start is high and o_busy is low. Results come on o_out, each marked
// by a one-cycle o_valid strobe; the receiver cannot stall, so every strobe is a
// delivered word. Flush gives one word per dirty unpinned frame, last marked.
// Configuration: i_cfg_valid with i_cfg_index (0 policy, 1 frames in use) and
// i_cfg_data; o_cfg_ready is always high; write only while o_busy is low.
// The n active frames are visited one per cycle by a single scan pointer. Pin,
// unpin, mark dirty and force first look the page up; a pin miss fills an empty
// frame, or else scans for an unpinned victim: FIFO and CLOCK from their hand to
// the first fit (CLOCK clearing reference bits on the way), LRU and LFU over all
// n frames. A flush with no dirty unpinned frame gives one empty word, last marked.
// The result strobe follows the final cycle; o_busy drops with it, so the next
// command may be taken while that strobe is up.
// Synchronous reset clears the frame table flags, hands, stamp and counters.
module page_buffer_replacement_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  pbr_pkg::t_in  i_in,
    output logic          o_valid,
    output pbr_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [6:0]    i_cfg_data
);

    pbr_pkg::t_ctl ctl;
    pbr_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    pbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_in.op),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy)
    );

    pbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> !o_busy)
        else $error("final word while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.last) |-> o_busy)
        else $error("non-final word outside a flush");

endmodule

>>> src/pbr_ctrl.sv
module pbr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_op,
    input  pbr_pkg::t_sts i_sts,
    output pbr_pkg::t_ctl o_ctl,
    output logic          o_busy
);

    pbr_pkg::t_state r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic [1:0]      r_stat, n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbr_pkg::S_IDLE;
            r_op    <= pbr_pkg::OP_PIN;
            r_stat  <= pbr_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_stat  <= n_stat;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_stat  = r_stat;
        unique case (r_state)
            pbr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    if (i_op == pbr_pkg::OP_PIN || i_op == pbr_pkg::OP_UNPIN ||
                        i_op == pbr_pkg::OP_DIRTY || i_op == pbr_pkg::OP_FORCE) begin
                        n_state = pbr_pkg::S_LOOK;
                    end else if (i_op == pbr_pkg::OP_FLUSH) begin
                        n_state = pbr_pkg::S_FLUSH;
                    end else begin
                        n_stat  = pbr_pkg::ST_NOTF;
                        n_state = pbr_pkg::S_RESP;
                    end
                end
            end
            pbr_pkg::S_LOOK: begin
                if (i_sts.look_done) n_state = pbr_pkg::S_DECIDE;
            end
            pbr_pkg::S_DECIDE: begin
                if (r_op == pbr_pkg::OP_PIN) begin
                    if (i_sts.found) begin
                        n_state = pbr_pkg::S_HIT;
                    end else if (i_sts.has_empty) begin
                        n_state = pbr_pkg::S_FILL;
                    end else if (!i_sts.any_unp) begin
                        n_stat  = pbr_pkg::ST_FULL;
                        n_state = pbr_pkg::S_RESP;
                    end else begin
                        n_state = pbr_pkg::S_VINIT;
                    end
                end else if (i_sts.found) begin
                    n_state = pbr_pkg::S_UPD;
                end else begin
                    n_stat  = pbr_pkg::ST_NOTF;
                    n_state = pbr_pkg::S_RESP;
                end
            end
            pbr_pkg::S_VINIT: n_state = pbr_pkg::S_VSCAN;
            pbr_pkg::S_VSCAN: begin
                if (i_sts.vict_done) n_state = pbr_pkg::S_SEEK;
            end
            pbr_pkg::S_SEEK:  n_state = pbr_pkg::S_FILL;
            pbr_pkg::S_FILL,
            pbr_pkg::S_HIT,
            pbr_pkg::S_UPD,
            pbr_pkg::S_RESP,
            pbr_pkg::S_FEND:  n_state = pbr_pkg::S_IDLE;
            pbr_pkg::S_FLUSH: begin
                if (i_sts.scan_end) n_state = pbr_pkg::S_FEND;
            end
            default:          n_state = pbr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.stat = r_stat;
        o_busy     = (r_state != pbr_pkg::S_IDLE);
        unique case (r_state)
            pbr_pkg::S_IDLE:   o_ctl.cmd = i_start ? pbr_pkg::CMD_LOAD : pbr_pkg::CMD_NONE;
            pbr_pkg::S_LOOK:   o_ctl.cmd = pbr_pkg::CMD_LOOK;
            pbr_pkg::S_DECIDE: o_ctl.cmd = pbr_pkg::CMD_DECIDE;
            pbr_pkg::S_VINIT:  o_ctl.cmd = pbr_pkg::CMD_VINIT;
            pbr_pkg::S_VSCAN:  o_ctl.cmd = pbr_pkg::CMD_VSCAN;
            pbr_pkg::S_SEEK:   o_ctl.cmd = pbr_pkg::CMD_SEEK;
            pbr_pkg::S_FILL:   o_ctl.cmd = pbr_pkg::CMD_FILL;
            pbr_pkg::S_HIT:    o_ctl.cmd = pbr_pkg::CMD_HIT;
            pbr_pkg::S_UPD:    o_ctl.cmd = pbr_pkg::CMD_UPD;
            pbr_pkg::S_RESP:   o_ctl.cmd = pbr_pkg::CMD_RESP;
            pbr_pkg::S_FLUSH:  o_ctl.cmd = pbr_pkg::CMD_FLUSH;
            pbr_pkg::S_FEND:   o_ctl.cmd = pbr_pkg::CMD_FEND;
            default:           o_ctl.cmd = pbr_pkg::CMD_NONE;
        endcase
    end

endmodule

>>> src/pbr_dp.sv
module pbr_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pbr_pkg::t_ctl i_ctl,
    input  pbr_pkg::t_in  i_in,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [6:0]    i_cfg_data,
    output pbr_pkg::t_sts o_sts,
    output logic          o_valid,
    output pbr_pkg::t_out o_out
);

    localparam int IW = pbr_pkg::IDX_W;
    localparam int PW = pbr_pkg::PAGE_W;
    localparam int SW = pbr_pkg::STAMP_W;
    localparam int CW = pbr_pkg::CNT_W;

    logic [PW-1:0] r_fpage  [pbr_pkg::FRAMES];
    logic          r_fvalid [pbr_pkg::FRAMES];
    logic          r_fdirty [pbr_pkg::FRAMES];
    logic [7:0]    r_fpins  [pbr_pkg::FRAMES];
    logic [SW-1:0] r_fstamp [pbr_pkg::FRAMES];
    logic          r_fref   [pbr_pkg::FRAMES];
    logic [15:0]   r_fuses  [pbr_pkg::FRAMES];

    logic [1:0]    r_policy;
    logic [6:0]    r_frames;
    logic [2:0]    r_op;
    logic [PW-1:0] r_page;
    logic [6:0]    r_n;
    logic [IW-1:0] r_idx, r_cnt, r_frm, r_empty;
    logic          r_empty_v, r_found, r_unp, r_have, r_victim;
    logic [SW-1:0] r_best_age, r_stamp;
    logic [15:0]   r_best_uses;
    logic [5:0]    r_fifo, r_clock, r_lfu;
    logic [CW-1:0] r_reads, r_writes;
    logic          r_pend_v, r_valid;
    pbr_pkg::t_out r_pend, r_out;

    logic [PW-1:0] cur_page;
    logic          cur_valid, cur_dirty, cur_ref, unp, match, idx_last, cnt_last;
    logic          flush_hit, upd_wb, out_now;
    logic [7:0]    cur_pins;
    logic [SW-1:0] cur_stamp, age, stamp_new;
    logic [15:0]   cur_uses;
    logic [IW-1:0] idx_next;
    logic [6:0]    n_clamp;

    function automatic pbr_pkg::t_out mk(
        input logic [1:0] status, input logic [IW-1:0] frame, input logic hit,
        input logic rd, input logic wbv, input logic [PW-1:0] wbp, input logic last,
        input logic [CW-1:0] reads, input logic [CW-1:0] writes);
        pbr_pkg::t_out o;
        o.status          = status;
        o.frame           = 6'(frame);
        o.hit             = hit;
        o.read_valid      = rd;
        o.writeback_valid = wbv;
        o.writeback_page  = wbp;
        o.last            = last;
        o.reads_total     = reads;
        o.writes_total    = writes;
        return o;
    endfunction

    assign cur_page  = r_fpage[r_idx];
    assign cur_valid = r_fvalid[r_idx];
    assign cur_dirty = r_fdirty[r_idx];
    assign cur_pins  = r_fpins[r_idx];
    assign cur_stamp = r_fstamp[r_idx];
    assign cur_ref   = r_fref[r_idx];
    assign cur_uses  = r_fuses[r_idx];
    assign unp       = (cur_pins == 8'd0);
    assign match     = cur_valid && (cur_page == r_page);
    assign age       = r_stamp - cur_stamp;
    assign stamp_new = r_stamp + SW'(1);
    assign idx_last  = (7'(r_idx) == r_n - 7'd1);
    assign cnt_last  = (7'(r_cnt) == r_n - 7'd1);
    assign idx_next  = idx_last ? '0 : r_idx + IW'(1);
    assign n_clamp   = (r_frames == 7'd0) ? 7'd1 :
                       (r_frames > 7'(pbr_pkg::FRAMES)) ? 7'(pbr_pkg::FRAMES) : r_frames;
    assign flush_hit = cur_valid && unp && cur_dirty;
    assign upd_wb    = (r_op == pbr_pkg::OP_FORCE);
    assign out_now   = (i_ctl.cmd == pbr_pkg::CMD_FILL) || (i_ctl.cmd == pbr_pkg::CMD_HIT) ||
                       (i_ctl.cmd == pbr_pkg::CMD_UPD) || (i_ctl.cmd == pbr_pkg::CMD_RESP) ||
                       (i_ctl.cmd == pbr_pkg::CMD_FEND) ||
                       (i_ctl.cmd == pbr_pkg::CMD_FLUSH && flush_hit && r_pend_v);

    always_comb begin
        o_sts.found     = r_found;
        o_sts.has_empty = r_empty_v;
        o_sts.any_unp   = r_unp;
        o_sts.look_done = match || idx_last;
        o_sts.scan_end  = idx_last;
        case (r_policy)
            pbr_pkg::POL_FIFO:  o_sts.vict_done = unp;
            pbr_pkg::POL_CLOCK: o_sts.vict_done = unp && !cur_ref;
            default:            o_sts.vict_done = cnt_last;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == pbr_pkg::CMD_FILL) r_fpage[r_idx] <= r_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pbr_pkg::FRAMES; i++) begin
                r_fvalid[i] <= 1'b0;
                r_fdirty[i] <= 1'b0;
                r_fpins[i]  <= '0;
                r_fstamp[i] <= '0;
                r_fref[i]   <= 1'b0;
                r_fuses[i]  <= '0;
            end
            r_policy    <= pbr_pkg::POL_FIFO;
            r_frames    <= 7'd8;
            r_op        <= pbr_pkg::OP_PIN;
            r_page      <= '0;
            r_n         <= 7'd1;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_frm       <= '0;
            r_empty     <= '0;
            r_empty_v   <= 1'b0;
            r_found     <= 1'b0;
            r_unp       <= 1'b0;
            r_have      <= 1'b0;
            r_victim    <= 1'b0;
            r_best_age  <= '0;
            r_best_uses <= '0;
            r_stamp     <= '0;
            r_fifo      <= '0;
            r_clock     <= '0;
            r_lfu       <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_pend_v    <= 1'b0;
            r_pend      <= '0;
            r_valid     <= 1'b0;
            r_out       <= '0;
        end else begin
            r_valid <= out_now;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pbr_pkg::CFG_POLICY: r_policy <= i_cfg_data[1:0];
                    pbr_pkg::CFG_FRAMES: r_frames <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_ctl.cmd)
                pbr_pkg::CMD_LOAD: begin
                    r_op      <= i_in.op;
                    r_page    <= i_in.page_num;
                    r_n       <= n_clamp;
                    r_idx     <= '0;
                    r_found   <= 1'b0;
                    r_empty_v <= 1'b0;
                    r_unp     <= 1'b0;
                    r_victim  <= 1'b0;
                    r_pend_v  <= 1'b0;
                end
                pbr_pkg::CMD_LOOK: begin
                    if (match) r_found <= 1'b1;
                    else       r_idx   <= idx_next;
                    if (!cur_valid && !r_empty_v) begin
                        r_empty_v <= 1'b1;
                        r_empty   <= r_idx;
                    end
                    if (unp) r_unp <= 1'b1;
                end
                pbr_pkg::CMD_DECIDE: begin
                    if (!r_found) r_idx <= r_empty;
                end
                pbr_pkg::CMD_VINIT: begin
                    r_cnt    <= '0;
                    r_have   <= 1'b0;
                    r_victim <= 1'b1;
                    case (r_policy)
                        pbr_pkg::POL_FIFO:
                            r_idx <= (7'(r_fifo) < r_n) ? IW'(r_fifo) : '0;
                        pbr_pkg::POL_CLOCK:
                            r_idx <= (7'(r_clock) < r_n) ? IW'(r_clock) : '0;
                        pbr_pkg::POL_LFU:
                            r_idx <= (7'(r_lfu) < r_n) ? IW'(r_lfu) : '0;
                        default:
                            r_idx <= '0;
                    endcase
                end
                pbr_pkg::CMD_VSCAN: begin
                    r_idx <= idx_next;
                    r_cnt <= r_cnt + IW'(1);
                    case (r_policy)
                        pbr_pkg::POL_FIFO: begin
                            if (unp) r_frm <= r_idx;
                        end
                        pbr_pkg::POL_LRU: begin
                            if (unp && (!r_have || age > r_best_age)) begin
                                r_frm      <= r_idx;
                                r_best_age <= age;
                                r_have     <= 1'b1;
                            end
                        end
                        pbr_pkg::POL_CLOCK: begin
                            if (unp) begin
                                if (cur_ref) r_fref[r_idx] <= 1'b0;
                                else         r_frm <= r_idx;
                            end
                        end
                        default: begin
                            if (unp && (!r_have || cur_uses < r_best_uses)) begin
                                r_frm       <= r_idx;
                                r_best_uses <= cur_uses;
                                r_have      <= 1'b1;
                            end
                        end
                    endcase
                end
                pbr_pkg::CMD_SEEK: r_idx <= r_frm;
                pbr_pkg::CMD_FILL: begin
                    r_fvalid[r_idx] <= 1'b1;
                    r_fdirty[r_idx] <= 1'b0;
                    r_fpins[r_idx]  <= 8'd1;
                    r_fstamp[r_idx] <= stamp_new;
                    r_fref[r_idx]   <= 1'b1;
                    r_fuses[r_idx]  <= '0;
                    r_stamp         <= stamp_new;
                    r_reads         <= r_reads + CW'(1);
                    r_writes        <= r_writes + CW'(cur_dirty);
                    r_out <= mk(pbr_pkg::ST_OK, r_idx, 1'b0, 1'b1, cur_dirty,
                                cur_dirty ? cur_page : '0, 1'b1,
                                r_reads + CW'(1), r_writes + CW'(cur_dirty));
                    if (r_victim) begin
                        case (r_policy)
                            pbr_pkg::POL_FIFO:  r_fifo  <= 6'(idx_next);
                            pbr_pkg::POL_CLOCK: r_clock <= 6'(idx_next);
                            pbr_pkg::POL_LFU:   r_lfu   <= 6'(idx_next);
                            default: ;
                        endcase
                    end
                end
                pbr_pkg::CMD_HIT: begin
                    if (cur_pins != 8'hFF) r_fpins[r_idx] <= cur_pins + 8'd1;
                    if (cur_uses != 16'hFFFF) r_fuses[r_idx] <= cur_uses + 16'd1;
                    r_fstamp[r_idx] <= stamp_new;
                    r_fref[r_idx]   <= 1'b1;
                    r_stamp         <= stamp_new;
                    r_out <= mk(pbr_pkg::ST_OK, r_idx, 1'b1, 1'b0, 1'b0, '0, 1'b1,
                                r_reads, r_writes);
                end
                pbr_pkg::CMD_UPD: begin
                    r_out <= mk(pbr_pkg::ST_OK, r_idx, 1'b0, 1'b0, upd_wb,
                                upd_wb ? cur_page : '0, 1'b1,
                                r_reads, r_writes + CW'(upd_wb));
                    case (r_op)
                        pbr_pkg::OP_UNPIN: begin
                            if (cur_pins != 8'd0) r_fpins[r_idx] <= cur_pins - 8'd1;
                        end
                        pbr_pkg::OP_DIRTY: r_fdirty[r_idx] <= 1'b1;
                        default: begin
                            r_fdirty[r_idx] <= 1'b0;
                            r_writes        <= r_writes + CW'(1);
                        end
                    endcase
                end
                pbr_pkg::CMD_RESP: begin
                    r_out <= mk(i_ctl.stat, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1,
                                r_reads, r_writes);
                end
                pbr_pkg::CMD_FLUSH: begin
                    r_idx <= idx_next;
                    if (flush_hit) begin
                        r_fdirty[r_idx] <= 1'b0;
                        r_writes        <= r_writes + CW'(1);
                        if (r_pend_v) r_out <= r_pend;
                        r_pend <= mk(pbr_pkg::ST_OK, r_idx, 1'b0, 1'b0, 1'b1, cur_page,
                                     1'b0, r_reads, r_writes + CW'(1));
                        r_pend_v <= 1'b1;
                    end
                end
                pbr_pkg::CMD_FEND: begin
                    if (r_pend_v) begin
                        r_out <= mk(r_pend.status, IW'(r_pend.frame), r_pend.hit,
                                    r_pend.read_valid, r_pend.writeback_valid,
                                    r_pend.writeback_page, 1'b1,
                                    r_pend.reads_total, r_pend.writes_total);
                    end else begin
                        r_out <= mk(pbr_pkg::ST_OK, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1,
                                    r_reads, r_writes);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule
